// ===== hw/rtl/lfwa_pkg.sv =====
// lfwa_pkg: shared widths, arithmetic constants and inter-module structs
// for the lowest free worker allocator; no dependencies
`default_nettype none

package lfwa_pkg;

    // field widths of the request and result items
    localparam int JOB_W       = 16;
    localparam int START_W     = 12;
    localparam int DUR_W       = 11;
    localparam int END_W       = 13;
    localparam int WID_W       = 4;
    localparam int NEED_W      = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;

    // shared multiplier operand widths
    localparam int MUL_A_W = 13;
    localparam int MUL_B_W = 13;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // hhmm conversion constants; divides done as reciprocal multiply and shift
    localparam logic [MUL_B_W-1:0] RECIP_100 = 13'd5243; // 2^19 / 100, rounded up
    localparam int                 SHIFT_100 = 19;
    localparam logic [MUL_B_W-1:0] RECIP_60  = 13'd4370; // 2^18 / 60, rounded up
    localparam int                 SHIFT_60  = 18;
    localparam logic [MUL_B_W-1:0] MIN_PER_H = 13'd60;
    localparam logic [MUL_B_W-1:0] HHMM_H    = 13'd100;

    // quotient widths after the shifts
    localparam int HOUR_W = 7; // hours incl. carry, at most 75
    localparam int CARRY_W = 6; // carried hours, at most 35
    localparam int MIN_W  = 12; // minutes before the carry, at most 2146

    // request from the allocator control to the end-time unit
    typedef struct packed {
        logic               go;
        logic [START_W-1:0] start_hhmm;
        logic [DUR_W-1:0]   duration_min;
    } t_calc_req;

    // status back from the end-time unit
    typedef struct packed {
        logic             done;
        logic [END_W-1:0] end_hhmm;
    } t_calc_rsp;

endpackage : lfwa_pkg

`default_nettype wire

// ===== hw/rtl/lfwa_ram.sv =====
// lfwa_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module lfwa_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule : lfwa_ram

`default_nettype wire

// ===== hw/rtl/lfwa_endcalc.sv =====
// lfwa_endcalc: hhmm end-time unit, one shared multiplier stepped by a small sequencer
// depends on lfwa_pkg
`default_nettype none

module lfwa_endcalc (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lfwa_pkg::t_calc_req i_req,
    output lfwa_pkg::t_calc_rsp      o_rsp
);
    import lfwa_pkg::*;

    typedef enum logic [8:0] {
        C_IDLE   = 9'b000000001,
        C_DIV100 = 9'b000000010,
        C_HMUL   = 9'b000000100,
        C_MSUM   = 9'b000001000,
        C_DIV60  = 9'b000010000,
        C_QMUL   = 9'b000100000,
        C_CARRY  = 9'b001000000,
        C_HHMM   = 9'b010000000,
        C_FINISH = 9'b100000000
    } t_calc_state;

    t_calc_state r_state, n_state;

    logic [START_W-1:0] r_start;
    logic [DUR_W-1:0]   r_dur;
    logic [MUL_P_W-1:0] r_prod;
    logic [HOUR_W-1:0]  r_hour;
    logic [CARRY_W-1:0] r_carry;
    logic [MIN_W-1:0]   r_min;
    logic [END_W-1:0]   r_end;
    logic               r_done;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [HOUR_W-1:0]  hour_q;
    logic [CARRY_W-1:0] carry_q;
    logic [END_W-1:0]   min_sum;

    // quotients taken straight off the registered product
    assign hour_q  = r_prod[SHIFT_100 +: HOUR_W];
    assign carry_q = r_prod[SHIFT_60 +: CARRY_W];

    // start minus whole hours plus duration, in end-time width
    assign min_sum = END_W'(r_start) + END_W'(r_dur) - r_prod[END_W-1:0];

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            C_DIV100: begin
                mul_a = MUL_A_W'(r_start);
                mul_b = RECIP_100;
            end
            C_HMUL: begin
                mul_a = MUL_A_W'(hour_q);
                mul_b = HHMM_H;
            end
            C_DIV60: begin
                mul_a = MUL_A_W'(r_min);
                mul_b = RECIP_60;
            end
            C_QMUL: begin
                mul_a = MUL_A_W'(carry_q);
                mul_b = MIN_PER_H;
            end
            C_HHMM: begin
                mul_a = MUL_A_W'(r_hour);
                mul_b = HHMM_H;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // step sequence
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE:   n_state = i_req.go ? C_DIV100 : C_IDLE;
            C_DIV100: n_state = C_HMUL;
            C_HMUL:   n_state = C_MSUM;
            C_MSUM:   n_state = C_DIV60;
            C_DIV60:  n_state = C_QMUL;
            C_QMUL:   n_state = C_CARRY;
            C_CARRY:  n_state = C_HHMM;
            C_HHMM:   n_state = C_FINISH;
            C_FINISH: n_state = C_IDLE;
            default:  n_state = C_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_req.go) begin
                r_done <= 1'b0;
            end else if (r_state == C_FINISH) begin
                r_done <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
        unique case (r_state)
            C_IDLE: begin
                if (i_req.go) begin
                    r_start <= i_req.start_hhmm;
                    r_dur   <= i_req.duration_min;
                end
            end
            C_HMUL:  r_hour  <= hour_q;
            C_MSUM:  r_min   <= min_sum[MIN_W-1:0];
            C_QMUL:  r_carry <= carry_q;
            C_CARRY: begin
                r_min  <= r_min - r_prod[MIN_W-1:0];
                r_hour <= r_hour + HOUR_W'(r_carry);
            end
            C_FINISH: r_end <= r_prod[END_W-1:0] + END_W'(r_min);
            default: begin
            end
        endcase
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.end_hhmm = r_end;

endmodule : lfwa_endcalc

`default_nettype wire

// ===== hw/rtl/lowest_free_worker_allocator.sv =====
// lowest_free_worker_allocator: top level, worker scan, busy flags and result register
// depends on lfwa_pkg, lfwa_ram and lfwa_endcalc
`default_nettype none

// Usage
// Requests enter on the s_axis group: tdata carries job_id, start_hhmm (hours*100 +
// minutes) and duration_min. Each request gives exactly one result on m_axis:
// tdata carries job_tag, worker_id and workers_needed, tuser carries no_worker.
// The block takes one request at a time. A request walks the end-time RAM one
// worker per cycle through its single read port and one compare, releasing every
// busy worker whose end time is at or before the start and picking the lowest
// free one; the end time is built meanwhile by the shared-multiplier unit in
// eight steps. A result is loaded once both the scan and the end time are done
// and the result register is free, and the next request is accepted in the cycle
// after the result is loaded, so no new request is taken before that.
// The result sits in an output register; a stalled receiver holds it there and
// the next request is still accepted, but its result waits until the register
// is taken. If no worker is free no_worker is set and no state changes.
// Synchronous active-low reset frees every worker and clears the peak count;
// the end-time RAM needs no clearing since an entry is used only while busy.
module lowest_free_worker_allocator #(
    parameter int WORKERS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // job_id[15:0], start_hhmm[27:16], duration_min[38:28], zero pad
    input  wire logic [lfwa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // job_tag[15:0], worker_id[19:16], workers_needed[24:20], zero pad
    output logic      [lfwa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // no_worker[0]
    output logic      [0:0]                         m_axis_tuser
);
    import lfwa_pkg::*;

    localparam int IW = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int CW = $clog2(WORKERS + 1);
    localparam int PW = $clog2(WORKERS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [WORKERS-1:0] r_busy;
    logic [PW-1:0]      r_peak;
    logic [CW-1:0]      r_cnt;
    logic               r_rd_vld;
    logic [IW-1:0]      r_rd_idx;
    logic               r_found;
    logic [IW-1:0]      r_pick;
    logic [JOB_W-1:0]   r_tag;
    logic [START_W-1:0] r_start;

    logic               r_out_valid;
    logic [JOB_W-1:0]   r_out_tag;
    logic [WID_W-1:0]   r_out_wid;
    logic [NEED_W-1:0]  r_out_need;
    logic               r_out_nw;

    logic               in_acc;
    logic               out_free;
    logic               scan_end;
    logic               is_free;
    logic [END_W-1:0]   rd_end;
    logic [PW-1:0]      pick_inc;
    logic [PW-1:0]      n_peak;
    logic [PW+NEED_W-1:0] peak_ext;
    logic [IW+WID_W-1:0]  pick_ext;
    t_calc_req          calc_req;
    t_calc_rsp          calc_rsp;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign scan_end = (r_cnt == CW'(WORKERS)) && !r_rd_vld;

    // end-time unit
    assign calc_req.go           = in_acc;
    assign calc_req.start_hhmm   = s_axis_tdata[JOB_W +: START_W];
    assign calc_req.duration_min = s_axis_tdata[JOB_W + START_W +: DUR_W];

    lfwa_endcalc u_endcalc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (calc_req),
        .o_rsp   (calc_rsp)
    );

    // end times per worker
    lfwa_ram #(
        .WIDTH (END_W),
        .DEPTH (WORKERS)
    ) u_end_ram (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_DONE) && out_free && r_found),
        .i_waddr (r_pick),
        .i_wdata (calc_rsp.end_hhmm),
        .i_raddr (r_cnt[IW-1:0]),
        .o_rdata (rd_end)
    );

    // release test for the entry coming out of the ram
    assign is_free = !r_busy[r_rd_idx] || (rd_end <= END_W'(r_start));

    // peak update for the picked worker
    assign pick_inc = PW'(r_pick) + PW'(1);
    assign n_peak   = (r_found && (pick_inc > r_peak)) ? pick_inc : r_peak;
    assign peak_ext = {{NEED_W{1'b0}}, n_peak};
    assign pick_ext = {{WID_W{1'b0}}, r_pick};

    // request sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: n_state = in_acc ? S_SCAN : S_IDLE;
            S_SCAN: n_state = (scan_end && calc_rsp.done) ? S_DONE : S_SCAN;
            S_DONE: n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= '0;
            r_peak      <= '0;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // result register loads a new result or is emptied by the receiver
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cnt    <= '0;
                    r_rd_vld <= 1'b0;
                    r_found  <= 1'b0;
                end
                S_SCAN: begin
                    // issue one read a cycle, compare it the cycle after
                    r_rd_vld <= (r_cnt != CW'(WORKERS));
                    if (r_cnt != CW'(WORKERS)) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    if (r_rd_vld && is_free) begin
                        r_busy[r_rd_idx] <= 1'b0;
                        if (!r_found) begin
                            r_found <= 1'b1;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_peak <= n_peak;
                        if (r_found) begin
                            r_busy[r_pick] <= 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_tag   <= s_axis_tdata[JOB_W-1:0];
            r_start <= s_axis_tdata[JOB_W +: START_W];
        end
        r_rd_idx <= r_cnt[IW-1:0];
        if ((r_state == S_SCAN) && r_rd_vld && is_free && !r_found) begin
            r_pick <= r_rd_idx;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_tag  <= r_tag;
            r_out_wid  <= r_found ? pick_ext[WID_W-1:0] : '0;
            r_out_need <= peak_ext[NEED_W-1:0];
            r_out_nw   <= !r_found;
        end
    end

    // result channel
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - JOB_W - WID_W - NEED_W){1'b0}},
                            r_out_need, r_out_wid, r_out_tag};
    assign m_axis_tuser  = r_out_nw;

`ifndef SYNTHESIS
    // a dropped job means every worker was used at some point
    a_full_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_nw) |-> (r_peak == PW'(WORKERS)))
        else $error("no_worker reported below full peak");

    // no worker at or above the peak can be busy
    a_busy_below_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_busy >> r_peak) == '0))
        else $error("busy worker above peak count");

    // the picked worker was released or free during the scan
    a_pick_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && r_found) |-> !r_busy[r_pick])
        else $error("picked worker still busy");
`endif

endmodule : lowest_free_worker_allocator

`default_nettype wire

// ===== dv/lfwa_checker.sv =====
// lfwa_checker: watches the request and result streams of the worker allocator,
// predicts each allocation and compares it field by field; depends on lfwa_pkg
`timescale 1ns / 1ps

module lfwa_checker #(
    parameter int WORKERS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_req_valid,
    input  wire logic                               i_req_ready,
    // job_id[15:0], start_hhmm[27:16], duration_min[38:28], zero pad
    input  wire logic [lfwa_pkg::IN_TDATA_W-1:0]    i_req_data,
    input  wire logic                               i_res_valid,
    input  wire logic                               i_res_ready,
    // job_tag[15:0], worker_id[19:16], workers_needed[24:20], zero pad
    input  wire logic [lfwa_pkg::OUT_TDATA_W-1:0]   i_res_data,
    // no_worker[0]
    input  wire logic [0:0]                         i_res_user,
    output int                                      o_errors,
    output int                                      o_pending
);

    import lfwa_pkg::*;

    // one predicted allocation
    typedef struct packed {
        logic [JOB_W-1:0]  tag;
        logic [WID_W-1:0]  worker;
        logic [NEED_W-1:0] needed;
        logic              refused;
    } t_alloc;

    logic             busy      [WORKERS];
    logic [END_W-1:0] finish_at [WORKERS];
    int               peak;
    t_alloc           awaited_q [$];
    int               err_count = 0;

    assign o_errors = err_count;

    // one line per mismatch
    task automatic report(input string what, input int got, input int want);
        $display("%0t ns lfwa_checker: %s got 0x%0h want 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    // end time in hhmm: minutes carried into hours, no wrap at midnight
    function automatic logic [END_W-1:0] hhmm_end(input int st, input int dur);
        int hrs;
        int mins;
        hrs  = st / 100;
        mins = st % 100 + dur;
        hrs  = hrs + mins / 60;
        mins = mins % 60;
        return END_W'(hrs * 100 + mins);
    endfunction

    // release finished workers, then hand the job to the lowest free one
    function automatic t_alloc allocate_job(input logic [IN_TDATA_W-1:0] req);
        logic [JOB_W-1:0]   id;
        logic [START_W-1:0] st;
        logic [DUR_W-1:0]   dur;
        logic [END_W-1:0]   fin;
        int                 pick;
        int                 w;
        t_alloc             res;
        id   = req[JOB_W-1:0];
        st   = req[JOB_W +: START_W];
        dur  = req[JOB_W + START_W +: DUR_W];
        fin  = hhmm_end(int'(st), int'(dur));
        pick = -1;
        for (w = 0; w < WORKERS; w++)
            if (busy[w] && int'(finish_at[w]) <= int'(st))
                busy[w] = 1'b0;
        for (w = WORKERS - 1; w >= 0; w--)
            if (!busy[w])
                pick = w;
        res.tag = id;
        if (pick < 0) begin
            // everyone busy: job dropped, nothing changes
            res.worker  = '0;
            res.needed  = NEED_W'(peak);
            res.refused = 1'b1;
        end else begin
            busy[pick]      = 1'b1;
            finish_at[pick] = fin;
            if (pick + 1 > peak)
                peak = pick + 1;
            res.worker  = WID_W'(pick);
            res.needed  = NEED_W'(peak);
            res.refused = 1'b0;
        end
        return res;
    endfunction

    // compare one accepted result with the oldest prediction
    task automatic check_result(input logic [OUT_TDATA_W-1:0] data, input logic flag);
        t_alloc want;
        if (awaited_q.size() == 0) begin
            report("result with no request outstanding", int'(data), 0);
            return;
        end
        want = awaited_q.pop_front();
        if (data[JOB_W-1:0] != want.tag)
            report("job_tag", int'(data[JOB_W-1:0]), int'(want.tag));
        if (data[JOB_W +: WID_W] != want.worker)
            report("worker_id", int'(data[JOB_W +: WID_W]), int'(want.worker));
        if (data[JOB_W + WID_W +: NEED_W] != want.needed)
            report("workers_needed", int'(data[JOB_W + WID_W +: NEED_W]), int'(want.needed));
        if (flag != want.refused)
            report("no_worker", int'(flag), int'(want.refused));
    endtask

    // results are checked before the request of the same edge is predicted
    always @(posedge i_clk) begin : watch
        int w;
        if (!i_rst_n) begin
            for (w = 0; w < WORKERS; w++) begin
                busy[w]      = 1'b0;
                finish_at[w] = '0;
            end
            peak = 0;
            awaited_q.delete();
        end else begin
            if (i_res_valid && i_res_ready)
                check_result(i_res_data, i_res_user[0]);
            if (i_req_valid && i_req_ready)
                awaited_q.insert(awaited_q.size(), allocate_job(i_req_data));
        end
        o_pending <= awaited_q.size();
    end

endmodule

// ===== dv/tb_lowest_free_worker_allocator.sv =====
// tb_lowest_free_worker_allocator: stimulus, stalls and verdict for the allocator
// depends on lfwa_pkg, the allocator RTL and lfwa_checker
`timescale 1ns / 1ps

module tb_lowest_free_worker_allocator;

    import lfwa_pkg::*;

    localparam int          RANDOM_JOBS = 650;
    localparam int          QUIET_JOBS  = 80;      // last part runs without idling
    localparam int          FULL_TAIL   = 20;      // full-range fields at the very end
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          DRAIN       = 60;
    localparam logic [11:0] FLUSH_START = 12'd4059; // releases every ordinary job

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;
    int                     errors;
    int                     pending;
    bit                     idle_on = 1'b1;
    int                     stall_left = 0;

    lowest_free_worker_allocator #(.WORKERS(16)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    lfwa_checker #(.WORKERS(16)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .i_res_data  (m_axis_tdata),
        .i_res_user  (m_axis_tuser),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // result side stalls in random bursts, started only while idling is on
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left    <= $urandom_range(0, 17);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb_lowest_free_worker_allocator: errors");
        $finish;
    end

    function automatic logic [11:0] to_hhmm(input int day_min);
        return 12'((day_min / 60) * 100 + day_min % 60);
    endfunction

    // present one request, with an optional gap in front; valid stays up afterwards
    task automatic post_job(input logic [15:0] id, input logic [11:0] st,
                            input logic [10:0] dur);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, dur, st, id};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    initial begin : stimulus
        int k;
        int rand_left;
        int ep_len;
        int crowd;
        int day_min;
        int dur;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: release at equal end time, fill every worker, refusal,
        // earlier start, minutes above 59, extreme fields
        post_job(16'h0000, 12'd0, 11'd0);
        post_job(16'hFFFF, 12'd0, 11'd1439);
        for (k = 0; k < 15; k++)
            post_job(16'(16'h1000 + k), 12'd100, 11'd600);
        post_job(16'hAAAA, 12'd100, 11'd30);
        post_job(16'h5555, 12'd1100, 11'd45);
        post_job(16'h1234, 12'd1050, 11'd5);
        post_job(16'h00FF, 12'd1299, 11'd0);
        post_job(16'hFF00, 12'd2359, 11'd1439);
        post_job(16'h8001, 12'd4095, 11'd2047);
        post_job(16'h7FFE, 12'd4095, 11'd0);
        post_job(16'h0F0F, FLUSH_START, 11'd0);

        // random episodes: mostly ordered runs of jobs at varying load
        rand_left = RANDOM_JOBS;
        while (rand_left > 0) begin
            idle_on = (rand_left > QUIET_JOBS) && ($urandom_range(0, 3) != 0);
            crowd   = $urandom_range(0, 2);
            day_min = $urandom_range(0, 900);
            ep_len  = $urandom_range(6, 40);
            if ($urandom_range(0, 2) == 0) begin
                post_job(16'($urandom), FLUSH_START, 11'd0);
                rand_left--;
            end
            for (k = 0; k < ep_len && rand_left > 0; k++) begin
                if (rand_left <= FULL_TAIL) begin
                    post_job(16'($urandom), 12'($urandom), 11'($urandom));
                end else if ($urandom_range(0, 9) == 0) begin
                    // out of order, minutes may exceed 59
                    post_job(16'($urandom), 12'($urandom_range(0, 2359)),
                             11'($urandom_range(0, 900)));
                end else begin
                    case (crowd)
                        0: begin
                            day_min = day_min + $urandom_range(0, 30);
                            dur     = $urandom_range(0, 120);
                        end
                        1: begin
                            day_min = day_min + $urandom_range(0, 10);
                            dur     = $urandom_range(30, 400);
                        end
                        default: begin
                            day_min = day_min + $urandom_range(0, 3);
                            dur     = $urandom_range(200, 900);
                        end
                    endcase
                    if (day_min > 1439)
                        day_min = 1439;
                    post_job(16'($urandom), to_hhmm(day_min), 11'(dur));
                end
                rand_left--;
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (errors == 0)
            $display("tb_lowest_free_worker_allocator: clean");
        else
            $display("tb_lowest_free_worker_allocator: errors");
        $finish;
    end

endmodule
